@@ hw/rtl/ehp_pkg.sv @@
// Shared types and constants for the Ethernet L2-L4 header parser.
`default_nettype none

package ehp_pkg;

  localparam int unsigned MaxFrameBytes = 65535;
  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;
  localparam logic [15:0] EtypeArp = 16'h0806;

  localparam logic [6:0] L4StartIpv4Base = 7'd14;
  localparam logic [6:0] L4StartIpv6 = 7'd54;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [15:0] PortHttp = 16'd80;
  localparam logic [15:0] PortHttps = 16'd443;
  localparam logic [15:0] PortDns = 16'd53;

  localparam logic [PosW-1:0] MinEthLen = PosW'(14);
  localparam logic [PosW-1:0] MinIpv4Len = PosW'(34);
  localparam logic [PosW-1:0] MinIpv6Len = PosW'(54);
  localparam logic [PosW-1:0] MinArpLen = PosW'(30);

  typedef enum logic [1:0] {
    ST_PARSED = 2'd0,
    ST_SHORT_ETH = 2'd1,
    ST_SHORT_L3 = 2'd2,
    ST_UNKNOWN_ETYPE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    L3_NONE = 2'd0,
    L3_IPV4 = 2'd1,
    L3_IPV6 = 2'd2,
    L3_ARP = 2'd3
  } l3_kind_e;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_TCP = 2'd1,
    L4_UDP = 2'd2
  } l4_kind_e;

  typedef enum logic [1:0] {
    APP_UNKNOWN = 2'd0,
    APP_HTTP = 2'd1,
    APP_HTTPS = 2'd2,
    APP_DNS = 2'd3
  } app_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    l3_kind_e   l3_kind;
    l4_kind_e   l4_kind;
    logic [7:0] ip_protocol;
    logic [7:0] hop_count;
    logic [1:0] frag_flags;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0] tcp_flags;
    app_class_e app_class;
    logic [15:0] body_len;
    logic [15:0] arp_operation;
  } out_item_t;

  // Per-frame record handed from the byte front end to the summary stage.
  typedef struct packed {
    logic [PosW-1:0] len;
    l3_kind_e   l3_kind;
    logic [6:0] l4_start;
    logic [7:0] proto;
    logic [7:0] hop;
    logic [1:0] frag;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0] tcp_flags;
    logic [5:0] tcp_hdr_bytes;
    logic [15:0] arp_op;
  } frame_rec_t;

endpackage

`default_nettype wire

@@ hw/rtl/ehp_front.sv @@
// Byte front end: counts positions, captures header fields, emits a frame record.
`default_nettype none

module ehp_front import ehp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire in_item_t   in_data_i,
  input  wire logic       space_i,
  output      logic       in_ready_o,
  output      logic       push_o,
  output      frame_rec_t rec_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0] eth_q, eth_d;
  logic [6:0]  l4s_q, l4s_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  hop_q, hop_d;
  logic [1:0]  frag_q, frag_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [5:0]  tfl_q, tfl_d;
  logic [5:0]  thb_q, thb_d;
  logic [15:0] arp_q, arp_d;

  logic            accept;
  logic            cap_en;
  logic [7:0]      b;
  logic            is4, is6, isarp, past_eth, in_l4;
  logic [PosW-1:0] rel;
  l3_kind_e        l3_kind;

  assign in_ready_o = space_i;
  assign accept = in_valid_i && in_ready_o;
  assign push_o = accept && in_data_i.last_byte;

  always_comb begin
    b = in_data_i.data_byte;
    cap_en = pos_q != PosW'(MaxFrameBytes);
    pos_d = cap_en ? pos_q + PosW'(1) : pos_q;

    eth_d = eth_q;
    if (cap_en && (pos_q == PosW'(12) || pos_q == PosW'(13))) begin
      eth_d = {eth_q[7:0], b};
    end

    is4 = eth_q == EtypeIpv4;
    is6 = eth_q == EtypeIpv6;
    isarp = eth_q == EtypeArp;
    past_eth = cap_en && (pos_q >= PosW'(14));

    l4s_d = l4s_q;
    if (past_eth && pos_q == PosW'(14) && (is4 || is6)) begin
      l4s_d = is4 ? L4StartIpv4Base + {1'b0, b[3:0], 2'b00} : L4StartIpv6;
    end

    frag_d = frag_q;
    hop_d = hop_q;
    proto_d = proto_q;
    arp_d = arp_q;
    if (past_eth) begin
      if (is4) begin
        if (pos_q == PosW'(20)) frag_d = b[6:5];
        if (pos_q == PosW'(22)) hop_d = b;
        if (pos_q == PosW'(23)) proto_d = b;
      end else if (is6) begin
        if (pos_q == PosW'(20)) proto_d = b;
        if (pos_q == PosW'(21)) hop_d = b;
      end else if (isarp) begin
        if (pos_q == PosW'(20)) arp_d[15:8] = b;
        if (pos_q == PosW'(21)) arp_d[7:0] = b;
      end
    end

    in_l4 = past_eth && (is4 || is6) && (pos_q >= PosW'(l4s_d));
    rel = pos_q - PosW'(l4s_d);
    src_d = src_q;
    dst_d = dst_q;
    thb_d = thb_q;
    tfl_d = tfl_q;
    if (in_l4) begin
      if (rel == PosW'(0)) src_d[15:8] = b;
      if (rel == PosW'(1)) src_d[7:0] = b;
      if (rel == PosW'(2)) dst_d[15:8] = b;
      if (rel == PosW'(3)) dst_d[7:0] = b;
      if (rel == PosW'(12)) thb_d = {b[7:4], 2'b00};
      if (rel == PosW'(13)) tfl_d = b[5:0];
    end

    if (eth_d == EtypeIpv4) begin
      l3_kind = L3_IPV4;
    end else if (eth_d == EtypeIpv6) begin
      l3_kind = L3_IPV6;
    end else if (eth_d == EtypeArp) begin
      l3_kind = L3_ARP;
    end else begin
      l3_kind = L3_NONE;
    end

    rec_o.len = pos_d;
    rec_o.l3_kind = l3_kind;
    rec_o.l4_start = l4s_d;
    rec_o.proto = proto_d;
    rec_o.hop = hop_d;
    rec_o.frag = frag_d;
    rec_o.source_port = src_d;
    rec_o.dest_port = dst_d;
    rec_o.tcp_flags = tfl_d;
    rec_o.tcp_hdr_bytes = thb_d;
    rec_o.arp_op = arp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      eth_q <= '0;
      l4s_q <= '0;
      proto_q <= '0;
      hop_q <= '0;
      frag_q <= '0;
      src_q <= '0;
      dst_q <= '0;
      tfl_q <= '0;
      thb_q <= '0;
      arp_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_byte) begin
        pos_q <= '0;
        eth_q <= '0;
        l4s_q <= '0;
        proto_q <= '0;
        hop_q <= '0;
        frag_q <= '0;
        src_q <= '0;
        dst_q <= '0;
        tfl_q <= '0;
        thb_q <= '0;
        arp_q <= '0;
      end else begin
        pos_q <= pos_d;
        eth_q <= eth_d;
        l4s_q <= l4s_d;
        proto_q <= proto_d;
        hop_q <= hop_d;
        frag_q <= frag_d;
        src_q <= src_d;
        dst_q <= dst_d;
        tfl_q <= tfl_d;
        thb_q <= thb_d;
        arp_q <= arp_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ehp_queue.sv @@
// Short queue of frame records between the front end and the summary stage.
`default_nettype none

module ehp_queue import ehp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire frame_rec_t push_data_i,
  output      logic       space_o,
  input  wire logic       pop_i,
  output      logic       head_valid_o,
  output      frame_rec_t head_o
);

  frame_rec_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign space_o = cnt_q != (QueuePtrW + 1)'(QueueDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_o = mem_q[rd_ptr_q];
  assign do_push = push_i && space_o;
  assign do_pop = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QueuePtrW + 1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (QueuePtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ehp_back.sv @@
// Summary stage: turns a frame record into a result item held in an output register.
`default_nettype none

module ehp_back import ehp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire frame_rec_t head_i,
  output      logic       pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      out_item_t  out_data_o
);

  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic               ip;
  logic signed [17:0] trans, pl;
  logic               hit80, hit443, hit53;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    out_d = '0;
    out_d.status = ST_PARSED;
    out_d.l3_kind = L3_NONE;
    out_d.l4_kind = L4_NONE;
    out_d.app_class = APP_UNKNOWN;
    ip = 1'b0;
    trans = $signed({2'b00, head_i.len}) - $signed({11'b0, head_i.l4_start});
    pl = '0;
    hit80 = head_i.source_port == PortHttp || head_i.dest_port == PortHttp;
    hit443 = head_i.source_port == PortHttps || head_i.dest_port == PortHttps;
    hit53 = head_i.source_port == PortDns || head_i.dest_port == PortDns;

    if (head_i.len < MinEthLen) begin
      out_d.status = ST_SHORT_ETH;
    end else begin
      unique case (head_i.l3_kind)
        L3_IPV4: begin
          out_d.l3_kind = L3_IPV4;
          if (head_i.len < MinIpv4Len) begin
            out_d.status = ST_SHORT_L3;
          end else begin
            out_d.frag_flags = head_i.frag;
            ip = 1'b1;
          end
        end
        L3_IPV6: begin
          out_d.l3_kind = L3_IPV6;
          if (head_i.len < MinIpv6Len) begin
            out_d.status = ST_SHORT_L3;
          end else begin
            ip = 1'b1;
          end
        end
        L3_ARP: begin
          out_d.l3_kind = L3_ARP;
          if (head_i.len < MinArpLen) begin
            out_d.status = ST_SHORT_L3;
          end else begin
            out_d.arp_operation = head_i.arp_op;
          end
        end
        default: begin
          out_d.status = ST_UNKNOWN_ETYPE;
        end
      endcase
    end

    if (ip) begin
      out_d.ip_protocol = head_i.proto;
      out_d.hop_count = head_i.hop;
      if (head_i.proto == ProtoTcp && trans >= 18'sd20) begin
        pl = trans - $signed({12'b0, head_i.tcp_hdr_bytes});
        out_d.l4_kind = L4_TCP;
        out_d.source_port = head_i.source_port;
        out_d.dest_port = head_i.dest_port;
        out_d.tcp_flags = head_i.tcp_flags;
        priority if (hit80) out_d.app_class = APP_HTTP;
        else if (hit443) out_d.app_class = APP_HTTPS;
        else if (hit53) out_d.app_class = APP_DNS;
        else out_d.app_class = APP_UNKNOWN;
        out_d.body_len = (pl > 18'sd0) ? pl[15:0] : 16'd0;
      end else if (head_i.proto == ProtoUdp && trans >= 18'sd8) begin
        pl = trans - 18'sd8;
        out_d.l4_kind = L4_UDP;
        out_d.source_port = head_i.source_port;
        out_d.dest_port = head_i.dest_port;
        out_d.app_class = hit53 ? APP_DNS : APP_UNKNOWN;
        out_d.body_len = (pl > 18'sd0) ? pl[15:0] : 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ethernet_l2_l4_header_parser.sv @@
// Ethernet L2-L4 header parser top level.
// Throughput: one byte item per cycle while the queue has space; a frame's summary item follows its last byte.
// The last byte's frame record is written into the record queue, then registered into
//   the output register once it is free; a two-entry record queue absorbs output stalls.
// Input stalls only when the record queue is full.
// Reset (async, active low) clears frame state, the queue and the output valid.
`default_nettype none

module ethernet_l2_l4_header_parser import ehp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  logic       push, space, pop, head_valid;
  frame_rec_t push_rec, head_rec;

  ehp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .space_i    (space),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  ehp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_rec),
    .space_o      (space),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_rec)
  );

  ehp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ehp_checker.sv @@
// Port-level checker for the header parser, bound to the top level.
`default_nettype none

module ehp_checker import ehp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item dropped or changed while stalled");

  a_short_eth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_SHORT_ETH |->
      out_data_o.l3_kind == L3_NONE && out_data_o.l4_kind == L4_NONE &&
      out_data_o.arp_operation == 16'd0)
    else $error("short frame carries header fields");

  a_no_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.l4_kind == L4_NONE |->
      out_data_o.source_port == 16'd0 && out_data_o.dest_port == 16'd0 &&
      out_data_o.body_len == 16'd0 && out_data_o.app_class == APP_UNKNOWN)
    else $error("L4 fields set without an L4 header");

  a_udp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.l4_kind == L4_UDP |->
      out_data_o.tcp_flags == 6'd0 &&
      (out_data_o.app_class == APP_UNKNOWN || out_data_o.app_class == APP_DNS))
    else $error("UDP item with TCP-only fields");

  a_arp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.l3_kind != L3_ARP |-> out_data_o.arp_operation == 16'd0)
    else $error("ARP opcode on non-ARP item");

endmodule

bind ethernet_l2_l4_header_parser ehp_checker u_ehp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
